### rtl/rgb_to_hsv_byte_convert_top_assert.svh
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSV_BYTE_CONVERT_TOP_ASSERT_SVH
`define RGB_TO_HSV_BYTE_CONVERT_TOP_ASSERT_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define RHSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in this cycle, consequent in the next.
`define RHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rhsv_pkg.sv
`timescale 1ns / 1ps

package rhsv_pkg;

	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned SAT_NUM_W   = 16;
	localparam int unsigned HUE_NUM_W   = 14;
	localparam int unsigned SAT_Q_W     = 8;
	localparam int unsigned HUE_Q_W     = 6;
	localparam int unsigned DIV_STAGES  = 8;
	localparam int unsigned DIV_IDX_W   = $clog2(SAT_Q_W);

	localparam logic [CHAN_W-1:0]    HUE_BASE_RED   = 8'd0;
	localparam logic [CHAN_W-1:0]    HUE_BASE_GREEN = 8'd85;
	localparam logic [CHAN_W-1:0]    HUE_BASE_BLUE  = 8'd171;
	localparam logic [HUE_NUM_W-1:0] HUE_STEP       = 14'd43;

	typedef struct packed {
		logic [SAT_NUM_W-1:0] sat_rem;
		logic [CHAN_W-1:0]    hi;
		logic [SAT_Q_W-1:0]   sat_q;
		logic [HUE_NUM_W-1:0] hue_rem;
		logic [CHAN_W-1:0]    span;
		logic [HUE_Q_W-1:0]   hue_q;
		logic                 neg;
		logic [CHAN_W-1:0]    base;
	} work_t;

	typedef struct packed {
		logic adv;
	} pipe_ctrl_t;

	function automatic work_t div_step(input work_t w, input logic [DIV_IDX_W-1:0] k);
		work_t                r;
		logic [SAT_NUM_W-1:0] sat_trial;
		logic [HUE_NUM_W-1:0] hue_trial;
		r         = w;
		sat_trial = SAT_NUM_W'(w.hi) << k;
		hue_trial = HUE_NUM_W'(w.span) << k;
		if (w.sat_rem >= sat_trial) begin
			r.sat_rem  = w.sat_rem - sat_trial;
			r.sat_q[k] = 1'b1;
		end
		if (k < HUE_Q_W) begin
			if (w.hue_rem >= hue_trial) begin
				r.hue_rem  = w.hue_rem - hue_trial;
				r.hue_q[k] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### rtl/rhsv_front.sv
`timescale 1ns / 1ps

module rhsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rhsv_pkg::pipe_ctrl_t ctrl,
	input  logic                in_valid,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	output logic                out_valid,
	output rhsv_pkg::work_t     out_work
);
	import rhsv_pkg::*;

	logic [CHAN_W-1:0] hi;
	logic [CHAN_W-1:0] lo;
	logic [CHAN_W-1:0] span;
	logic [CHAN_W:0]   diff;
	logic [CHAN_W-1:0] mag;
	logic [CHAN_W-1:0] base;
	work_t             work;
	logic              valid_s1;
	work_t             work_s1;

	always_comb begin
		hi = (red > green) ? red : green;
		hi = (hi > blue) ? hi : blue;
		lo = (red < green) ? red : green;
		lo = (lo < blue) ? lo : blue;
		span = hi - lo;
		priority if (hi == red) begin
			diff = {1'b0, green} - {1'b0, blue};
			base = HUE_BASE_RED;
		end else if (hi == green) begin
			diff = {1'b0, blue} - {1'b0, red};
			base = HUE_BASE_GREEN;
		end else begin
			diff = {1'b0, red} - {1'b0, green};
			base = HUE_BASE_BLUE;
		end
		mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
		work.sat_rem = (SAT_NUM_W'(span) << CHAN_W) - SAT_NUM_W'(span);
		work.hi      = hi;
		work.sat_q   = '0;
		work.hue_rem = HUE_NUM_W'(mag) * HUE_STEP;
		work.span    = span;
		work.hue_q   = '0;
		work.neg     = diff[CHAN_W];
		work.base    = base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctrl.adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			work_s1 <= work;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

### rtl/rhsv_div_pipe.sv
`timescale 1ns / 1ps

module rhsv_div_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rhsv_pkg::pipe_ctrl_t ctrl,
	input  logic                 in_valid,
	input  rhsv_pkg::work_t      in_work,
	output logic                 out_valid,
	output rhsv_pkg::work_t      out_work
);
	import rhsv_pkg::*;

	logic  valid_s [0:DIV_STAGES];
	work_t work_s  [0:DIV_STAGES];

	assign valid_s[0] = in_valid;
	assign work_s[0]  = in_work;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (ctrl.adv) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.adv) begin
				work_s[i+1] <= div_step(work_s[i], DIV_IDX_W'(DIV_STAGES - 1 - i));
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES];
	assign out_work  = work_s[DIV_STAGES];

endmodule

### rtl/rhsv_back.sv
`timescale 1ns / 1ps

module rhsv_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rhsv_pkg::pipe_ctrl_t ctrl,
	input  logic                 in_valid,
	input  rhsv_pkg::work_t      in_work,
	output logic                 out_valid,
	output logic [7:0]           hue,
	output logic [7:0]           sat,
	output logic [7:0]           val
);
	import rhsv_pkg::*;

	logic [CHAN_W-1:0] offset;
	logic [CHAN_W-1:0] hue_d;
	logic [CHAN_W-1:0] sat_d;
	logic              valid_q;
	logic [CHAN_W-1:0] hue_q;
	logic [CHAN_W-1:0] sat_q;
	logic [CHAN_W-1:0] val_q;

	always_comb begin
		offset = CHAN_W'(in_work.hue_q);
		if (in_work.neg) begin
			offset = -offset;
		end
		hue_d = (in_work.span == '0) ? '0 : in_work.base + offset;
		sat_d = (in_work.hi == '0) ? '0 : in_work.sat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			hue_q <= hue_d;
			sat_q <= sat_d;
			val_q <= in_work.hi;
		end
	end

	assign out_valid = valid_q;
	assign hue       = hue_q;
	assign sat       = sat_q;
	assign val       = val_q;

endmodule

### rtl/rgb_to_hsv_byte_convert_top.sv
// Throughput: one word per cycle; the min/max stage, eight restoring divide
// stages (one quotient bit each) and the output register advance together.
// A stalled output holds the whole pipeline; nothing is dropped.
// Reset (arst_n, asynchronous, active low) clears all valid bits.
`timescale 1ns / 1ps

module rgb_to_hsv_byte_convert_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // hue_out [7:0], sat_out [15:8], val_out [23:16]
);
	import rhsv_pkg::*;

	pipe_ctrl_t ctrl;
	logic       front_valid;
	work_t      front_work;
	logic       div_valid;
	work_t      div_work;
	logic [7:0] hue;
	logic [7:0] sat;
	logic [7:0] val;

	assign ctrl.adv = !m_tvalid || m_tready;
	assign s_tready = ctrl.adv;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (s_tvalid),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (front_valid),
		.out_work  (front_work)
	);

	rhsv_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (front_valid),
		.in_work   (front_work),
		.out_valid (div_valid),
		.out_work  (div_work)
	);

	rhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (div_valid),
		.in_work   (div_work),
		.out_valid (m_tvalid),
		.hue       (hue),
		.sat       (sat),
		.val       (val)
	);

	assign m_tdata = {val, sat, hue};

endmodule

### rtl/rhsv_checker.sv
`timescale 1ns / 1ps
`include "rgb_to_hsv_byte_convert_top_assert.svh"

module rhsv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	`RHSV_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
	`RHSV_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready, "input not ready with output empty")
	`RHSV_ASSERT_NOW(a_black_zero, clk, arst_n, m_tvalid && m_tdata[23:16] == 8'd0, m_tdata[15:0] == 16'd0, "black pixel with non-zero hue or saturation")
	`RHSV_ASSERT_NOW(a_grey_hue, clk, arst_n, m_tvalid && m_tdata[15:8] == 8'd0, m_tdata[7:0] == 8'd0, "zero saturation with non-zero hue")

endmodule

bind rgb_to_hsv_byte_convert_top rhsv_checker u_rhsv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import rhsv_pkg::*;

	localparam int unsigned CLK_PERIOD   = 12;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned HOLD_AT_WORD = 150;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		chan_t val;
		chan_t sat;
		chan_t hue;
	} hsv_t;

	class hsv_scoreboard;
		hsv_t expected_hsv[$];
		int   errors;

		function new();
			errors = 0;
		endfunction

		function hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
			int   rc, gc, bc, hi, lo, span, sat, hue;
			hsv_t res;
			rc = r;
			gc = g;
			bc = b;
			hi = (rc > gc) ? rc : gc;
			hi = (hi > bc) ? hi : bc;
			lo = (rc < gc) ? rc : gc;
			lo = (lo < bc) ? lo : bc;
			span = hi - lo;
			res = '0;
			res.val = hi[7:0];
			if (hi == 0)
				return res;
			sat = (255 * span) / hi;
			res.sat = sat[7:0];
			if (sat == 0 || span == 0)
				return res;
			if (hi == rc)
				hue = 0 + (43 * (gc - bc)) / span;
			else if (hi == gc)
				hue = 85 + (43 * (bc - rc)) / span;
			else
				hue = 171 + (43 * (rc - gc)) / span;
			res.hue = hue[7:0];
			return res;
		endfunction

		function void note_pixel(chan_t r, chan_t g, chan_t b);
			expected_hsv.push_back(predict_hsv(r, g, b));
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_hsv(logic [23:0] word);
			hsv_t got, exp;
			got = word;
			if (expected_hsv.size() == 0) begin
				flag($sformatf("unexpected output word %h", word));
				return;
			end
			exp = expected_hsv.pop_front();
			if (got.hue !== exp.hue)
				flag($sformatf("hue: expected %0d, got %0d", exp.hue, got.hue));
			if (got.sat !== exp.sat)
				flag($sformatf("sat: expected %0d, got %0d", exp.sat, got.sat));
			if (got.val !== exp.val)
				flag($sformatf("val: expected %0d, got %0d", exp.val, got.val));
		endfunction

		function int pending();
			return expected_hsv.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	hsv_scoreboard sb;
	int unsigned   sent_words;
	int unsigned   got_words;
	int unsigned   cycle_count;

	rgb_to_hsv_byte_convert_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2.0) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned draw_gap(int unsigned n);
		if ((n % 64) < 16)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	task automatic send_pixel(chan_t r, chan_t g, chan_t b);
		int unsigned gap;
		gap = draw_gap(sent_words);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {b, g, r};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pixel(r, g, b);
		sent_words++;
	endtask

	task automatic send_random_pixel();
		chan_t r, g, b, m;
		chan_t corner[4];
		corner = '{8'd0, 8'd1, 8'd254, 8'd255};
		r = $urandom_range(0, 255);
		g = $urandom_range(0, 255);
		b = $urandom_range(0, 255);
		case ($urandom_range(0, 9))
			5: begin
				g = r;
				b = r;
			end
			6: begin
				m = $urandom_range(1, 255);
				case ($urandom_range(0, 2))
					0: begin
						r = m;
						g = m;
						b = $urandom_range(0, m);
					end
					1: begin
						g = m;
						b = m;
						r = $urandom_range(0, m);
					end
					default: begin
						r = m;
						b = m;
						g = $urandom_range(0, m);
					end
				endcase
			end
			7: begin
				case ($urandom_range(0, 2))
					0: r = '0;
					1: g = '0;
					default: b = '0;
				endcase
			end
			8: begin
				r = $urandom_range(0, 3);
				g = $urandom_range(0, 3);
				b = $urandom_range(0, 3);
			end
			9: begin
				r = corner[$urandom_range(0, 3)];
				g = corner[$urandom_range(0, 3)];
				b = corner[$urandom_range(0, 3)];
			end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	// result side: random stalls, one long hold to back the pipeline up
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (got_words == HOLD_AT_WORD) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = draw_gap(got_words);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_hsv(m_tdata);
			got_words++;
		end
	end

	initial begin
		sb          = new();
		sent_words  = 0;
		got_words   = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd200, 8'd10,  8'd50);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd255);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd10,  8'd20,  8'd30);
		send_pixel(8'd170, 8'd85,  8'd255);
		send_pixel(8'd85,  8'd170, 8'd170);

		repeat (RANDOM_WORDS) send_random_pixel();
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
